// ===== rtl/qalu_pkg.sv =====
`default_nettype none

package qalu_pkg;

    typedef enum logic [3:0] {
        OP_MUL   = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_NEG   = 4'd3,
        OP_CONJ  = 4'd4,
        OP_DOT   = 4'd5,
        OP_LENSQ = 4'd6,
        OP_LEN   = 4'd7,
        OP_NORM  = 4'd8,
        OP_INV   = 4'd9,
        OP_CMP   = 4'd10
    } op_t;

    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;

    localparam logic [1:0] ORD_GT = 2'b01;
    localparam logic [1:0] ORD_EQ = 2'b00;
    localparam logic [1:0] ORD_LT = 2'b11;

    // Lane 0 is x, lane 3 is w.
    typedef struct packed {
        logic [3:0][31:0] q;
        logic [31:0]      scalar;
        logic [1:0]       order;
        logic             sat;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/qalu_mac.sv =====
`default_nettype none

module qalu_mac #(
    parameter int FRAC_BITS = 16
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      ce,
    input  wire                      in_valid,
    input  wire  [3:0]               in_cmd,
    input  wire  [3:0][31:0]         in_lhs,
    input  wire  [3:0][31:0]         in_rhs,
    output logic                     out_valid,
    output qalu_pkg::res_t           out_res,
    output logic [3:0]               out_cmd,
    output logic [64:0]              out_sqa,
    output logic [64-FRAC_BITS:0]    out_lsq,
    output logic [3:0][31:0]         out_mag,
    output logic [3:0]               out_neg
);

    localparam logic signed [66:0] HALF  = 67'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [66:0] R_MAX = 67'sd2147483647;
    localparam logic signed [66:0] R_MIN = -67'sd2147483648;

    // Rounds a sum of products to nearest (ties up) and clips it; bit 32 is the clip flag.
    function automatic logic [32:0] round_sat(input logic signed [65:0] s);
        logic signed [66:0] t;
        logic signed [66:0] r;
        t = $signed({s[65], s}) + HALF;
        r = t >>> FRAC_BITS;
        if (r > R_MAX) return {1'b1, qalu_pkg::INT_MAX};
        if (r < R_MIN) return {1'b1, qalu_pkg::INT_MIN};
        return {1'b0, r[31:0]};
    endfunction

    function automatic logic signed [65:0] sx66(input logic signed [63:0] p);
        return {{2{p[63]}}, p};
    endfunction

    function automatic logic [32:0] add_sat(input logic [31:0] a, input logic [31:0] b,
                                            input logic sub);
        logic [32:0] s;
        s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
        if (s[32] != s[31]) return {1'b1, s[32] ? qalu_pkg::INT_MIN : qalu_pkg::INT_MAX};
        return {1'b0, s[31:0]};
    endfunction

    // Stage A: products.
    logic                     a_valid_reg;
    logic [3:0]               a_cmd_reg;
    logic [3:0][31:0]         a_lhs_reg, a_rhs_reg;
    logic signed [63:0]       a_prod_reg [4][4];
    logic signed [63:0]       a_lsq_reg [4];
    logic signed [63:0]       a_rsq_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (ce) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_cmd_reg <= in_cmd;
            a_lhs_reg <= in_lhs;
            a_rhs_reg <= in_rhs;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    a_prod_reg[i][j] <= $signed(in_lhs[i]) * $signed(in_rhs[j]);
                end
                a_lsq_reg[i] <= $signed(in_lhs[i]) * $signed(in_lhs[i]);
                a_rsq_reg[i] <= $signed(in_rhs[i]) * $signed(in_rhs[i]);
            end
        end
    end

    // Stage B: exact sums of products.
    logic                     b_valid_reg;
    logic [3:0]               b_cmd_reg;
    logic [3:0][31:0]         b_lhs_reg, b_rhs_reg;
    logic signed [65:0]       b_ham_reg [4];
    logic signed [65:0]       b_dot_reg;
    logic [64:0]              b_sqa_reg, b_sqb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (ce) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            b_cmd_reg <= a_cmd_reg;
            b_lhs_reg <= a_lhs_reg;
            b_rhs_reg <= a_rhs_reg;
            b_ham_reg[0] <= sx66(a_prod_reg[3][0]) + sx66(a_prod_reg[0][3])
                          + sx66(a_prod_reg[1][2]) - sx66(a_prod_reg[2][1]);
            b_ham_reg[1] <= sx66(a_prod_reg[3][1]) - sx66(a_prod_reg[0][2])
                          + sx66(a_prod_reg[1][3]) + sx66(a_prod_reg[2][0]);
            b_ham_reg[2] <= sx66(a_prod_reg[3][2]) + sx66(a_prod_reg[0][1])
                          - sx66(a_prod_reg[1][0]) + sx66(a_prod_reg[2][3]);
            b_ham_reg[3] <= sx66(a_prod_reg[3][3]) - sx66(a_prod_reg[0][0])
                          - sx66(a_prod_reg[1][1]) - sx66(a_prod_reg[2][2]);
            b_dot_reg <= sx66(a_prod_reg[0][0]) + sx66(a_prod_reg[1][1])
                       + sx66(a_prod_reg[2][2]) + sx66(a_prod_reg[3][3]);
            b_sqa_reg <= {1'b0, a_lsq_reg[0]} + {1'b0, a_lsq_reg[1]}
                       + {1'b0, a_lsq_reg[2]} + {1'b0, a_lsq_reg[3]};
            b_sqb_reg <= {1'b0, a_rsq_reg[0]} + {1'b0, a_rsq_reg[1]}
                       + {1'b0, a_rsq_reg[2]} + {1'b0, a_rsq_reg[3]};
        end
    end

    // Stage C: rounding, saturation and the operations that need no square root or division.
    qalu_pkg::res_t           res_next;
    logic [65:0]              lsq_wide;
    logic [3:0][31:0]         mag_next;
    logic [3:0]               neg_next;
    logic [32:0]              rs;

    always_comb begin
        res_next = '0;
        rs       = '0;
        case (b_cmd_reg)
            qalu_pkg::OP_MUL: begin
                for (int k = 0; k < 4; k++) begin
                    rs = round_sat(b_ham_reg[k]);
                    res_next.q[k] = rs[31:0];
                    res_next.sat  = res_next.sat | rs[32];
                end
            end
            qalu_pkg::OP_ADD, qalu_pkg::OP_SUB: begin
                for (int k = 0; k < 4; k++) begin
                    rs = add_sat(b_lhs_reg[k], b_rhs_reg[k],
                                 b_cmd_reg == qalu_pkg::OP_SUB);
                    res_next.q[k] = rs[31:0];
                    res_next.sat  = res_next.sat | rs[32];
                end
            end
            qalu_pkg::OP_NEG, qalu_pkg::OP_CONJ: begin
                for (int k = 0; k < 4; k++) begin
                    rs = add_sat(32'd0, b_lhs_reg[k], 1'b1);
                    if (k == 3 && b_cmd_reg == qalu_pkg::OP_CONJ) begin
                        res_next.q[k] = b_lhs_reg[k];
                    end else begin
                        res_next.q[k] = rs[31:0];
                        res_next.sat  = res_next.sat | rs[32];
                    end
                end
            end
            qalu_pkg::OP_DOT: begin
                rs = round_sat(b_dot_reg);
                res_next.scalar = rs[31:0];
                res_next.sat    = rs[32];
            end
            qalu_pkg::OP_LENSQ: begin
                rs = round_sat({1'b0, b_sqa_reg});
                res_next.scalar = rs[31:0];
                res_next.sat    = rs[32];
            end
            qalu_pkg::OP_CMP: begin
                if (b_sqa_reg > b_sqb_reg) begin
                    res_next.order = qalu_pkg::ORD_GT;
                end else if (b_sqa_reg < b_sqb_reg) begin
                    res_next.order = qalu_pkg::ORD_LT;
                end else begin
                    res_next.order = qalu_pkg::ORD_EQ;
                end
            end
            default: begin
                res_next = '0;
            end
        endcase
    end

    always_comb begin
        lsq_wide = ({1'b0, b_sqa_reg} + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        for (int k = 0; k < 4; k++) begin
            mag_next[k] = b_lhs_reg[k][31] ? (~b_lhs_reg[k] + 32'd1) : b_lhs_reg[k];
            // Inverse divides the conjugate, so the vector part changes sign.
            if (b_cmd_reg == qalu_pkg::OP_INV && k < 3) begin
                neg_next[k] = ~b_lhs_reg[k][31];
            end else begin
                neg_next[k] = b_lhs_reg[k][31];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (ce) begin
            out_valid <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_res <= res_next;
            out_cmd <= b_cmd_reg;
            out_sqa <= b_sqa_reg;
            out_lsq <= lsq_wide[64-FRAC_BITS:0];
            out_mag <= mag_next;
            out_neg <= neg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qalu_sqrt.sv =====
`default_nettype none

module qalu_sqrt #(
    parameter int SIDE_W = 8
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 ce,
    input  wire                 in_valid,
    input  wire  [63:0]         in_rad,
    input  wire                 in_big,
    input  wire  [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [32:0]         out_len,
    output logic [SIDE_W-1:0]   out_side
);

    // One result bit per stage, most significant first.
    logic              st_valid_reg [1:32];
    logic [32:0]       st_rem_reg   [1:32];
    logic [31:0]       st_root_reg  [1:32];
    logic [63:0]       st_rad_reg   [1:32];
    logic              st_big_reg   [1:32];
    logic [SIDE_W-1:0] st_side_reg  [1:32];

    for (genvar k = 0; k < 32; k++) begin : g_stage
        logic              p_valid;
        logic [32:0]       p_rem;
        logic [31:0]       p_root;
        logic [63:0]       p_rad;
        logic              p_big;
        logic [SIDE_W-1:0] p_side;
        logic [34:0]       cur;
        logic [34:0]       trial;
        logic [32:0]       rem_next;
        logic [31:0]       root_next;

        if (k == 0) begin : g_first
            assign p_valid = in_valid;
            assign p_rem   = '0;
            assign p_root  = '0;
            assign p_rad   = in_rad;
            assign p_big   = in_big;
            assign p_side  = in_side;
        end else begin : g_next
            assign p_valid = st_valid_reg[k];
            assign p_rem   = st_rem_reg[k];
            assign p_root  = st_root_reg[k];
            assign p_rad   = st_rad_reg[k];
            assign p_big   = st_big_reg[k];
            assign p_side  = st_side_reg[k];
        end

        always_comb begin
            cur   = {p_rem, p_rad[2*(31-k)+1 -: 2]};
            trial = {1'b0, p_root, 2'b01};
            if (cur >= trial) begin
                rem_next  = 33'(cur - trial);
                root_next = {p_root[30:0], 1'b1};
            end else begin
                rem_next  = cur[32:0];
                root_next = {p_root[30:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_valid_reg[k+1] <= 1'b0;
            end else if (ce) begin
                st_valid_reg[k+1] <= p_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                st_rem_reg[k+1]  <= rem_next;
                st_root_reg[k+1] <= root_next;
                st_rad_reg[k+1]  <= p_rad;
                st_big_reg[k+1]  <= p_big;
                st_side_reg[k+1] <= p_side;
            end
        end
    end

    // A sum of squares of 2^64 only arises from four most-negative components.
    assign out_valid = st_valid_reg[32];
    assign out_len   = st_big_reg[32] ? {1'b1, 32'd0} : {1'b0, st_root_reg[32]};
    assign out_side  = st_side_reg[32];

endmodule

`default_nettype wire

// ===== rtl/qalu_div.sv =====
`default_nettype none

module qalu_div #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 8
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      ce,
    input  wire                      in_valid,
    input  wire  [64-FRAC_BITS:0]    in_divisor,
    input  wire  [3:0][31:0]         in_mag,
    input  wire  [3:0]               in_neg,
    input  wire  [SIDE_W-1:0]        in_side,
    output logic                     out_valid,
    output logic [3:0][31:0]         out_quo,
    output logic [3:0]               out_ovf,
    output logic [3:0]               out_neg,
    output logic [SIDE_W-1:0]        out_side
);

    localparam int DW = 65 - FRAC_BITS;
    localparam int NW = 32 + FRAC_BITS;

    logic              st_valid_reg [0:32];
    logic [DW-1:0]     st_div_reg   [0:32];
    logic [SIDE_W-1:0] st_side_reg  [0:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg[0] <= 1'b0;
        end else if (ce) begin
            st_valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            st_div_reg[0]  <= in_divisor;
            st_side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= 32; k++) begin : g_ctl
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_valid_reg[k] <= 1'b0;
            end else if (ce) begin
                st_valid_reg[k] <= st_valid_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                st_div_reg[k]  <= st_div_reg[k-1];
                st_side_reg[k] <= st_side_reg[k-1];
            end
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [DW-1:0] rem_reg [0:32];
        logic [31:0]   quo_reg [0:32];
        logic [31:0]   nlo_reg [0:32];
        logic          ovf_reg [0:32];
        logic          neg_reg [0:32];
        logic [NW-1:0] num;
        logic [DW-1:0] head;

        // The quotient reaches 2^32 exactly when the upper dividend bits reach the divisor.
        assign num  = {in_mag[l], {FRAC_BITS{1'b0}}};
        assign head = {{(DW-FRAC_BITS){1'b0}}, num[NW-1:32]};

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[0] <= head;
                quo_reg[0] <= '0;
                nlo_reg[0] <= num[31:0];
                ovf_reg[0] <= (head >= in_divisor);
                neg_reg[0] <= in_neg[l];
            end
        end

        for (genvar k = 1; k <= 32; k++) begin : g_bit
            logic [DW:0]   cur;
            logic [DW-1:0] rem_next;
            logic [31:0]   quo_next;

            always_comb begin
                cur = {rem_reg[k-1], nlo_reg[k-1][32-k]};
                if (cur >= {1'b0, st_div_reg[k-1]}) begin
                    rem_next = DW'(cur - {1'b0, st_div_reg[k-1]});
                    quo_next = {quo_reg[k-1][30:0], 1'b1};
                end else begin
                    rem_next = cur[DW-1:0];
                    quo_next = {quo_reg[k-1][30:0], 1'b0};
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[k] <= rem_next;
                    quo_reg[k] <= quo_next;
                    nlo_reg[k] <= nlo_reg[k-1];
                    ovf_reg[k] <= ovf_reg[k-1];
                    neg_reg[k] <= neg_reg[k-1];
                end
            end
        end

        assign out_quo[l] = quo_reg[32];
        assign out_ovf[l] = ovf_reg[32];
        assign out_neg[l] = neg_reg[32];
    end

    assign out_valid = st_valid_reg[32];
    assign out_side  = st_side_reg[32];

endmodule

`default_nettype wire

// ===== rtl/quaternion_alu_core.sv =====
`default_nettype none

// Throughput: one transaction per cycle while the output register is empty or being taken;
// the 32-stage square root and the 33-stage divider lanes are fully pipelined and every
// operation takes the same path. The whole pipeline advances whenever the output register
// is empty or being taken. Reset clears every valid bit and sets epsilon to 1.
module quaternion_alu_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_wr_en,
    input  wire  [15:0]  cfg_wr_data,
    input  wire          s_tvalid,
    output logic         s_tready,
    // command, lhs_x, lhs_y, lhs_z, lhs_w, rhs_x, rhs_y, rhs_z, rhs_w
    input  wire  [263:0] s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // out_x, out_y, out_z, out_w, scalar, order, saturated
    output logic [167:0] m_tdata
);

    localparam int DW = 65 - FRAC_BITS;

    typedef struct packed {
        qalu_pkg::res_t   res;
        logic [3:0]       cmd;
        logic [DW-1:0]    lsq;
        logic [3:0][31:0] mag;
        logic [3:0]       neg;
    } root_side_t;

    typedef struct packed {
        qalu_pkg::res_t res;
        logic [3:0]     cmd;
        logic           ident;
        logic [32:0]    len;
    } div_side_t;

    logic        ce;
    logic [15:0] eps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= 16'd1;
        end else if (cfg_wr_en) begin
            eps_reg <= cfg_wr_data;
        end
    end

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    logic [3:0][31:0] in_lhs, in_rhs;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            in_lhs[k] = s_tdata[4 + 32*k +: 32];
            in_rhs[k] = s_tdata[132 + 32*k +: 32];
        end
    end

    logic             mac_valid;
    qalu_pkg::res_t   mac_res;
    logic [3:0]       mac_cmd;
    logic [64:0]      mac_sqa;
    logic [DW-1:0]    mac_lsq;
    logic [3:0][31:0] mac_mag;
    logic [3:0]       mac_neg;

    qalu_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .in_cmd    (s_tdata[3:0]),
        .in_lhs    (in_lhs),
        .in_rhs    (in_rhs),
        .out_valid (mac_valid),
        .out_res   (mac_res),
        .out_cmd   (mac_cmd),
        .out_sqa   (mac_sqa),
        .out_lsq   (mac_lsq),
        .out_mag   (mac_mag),
        .out_neg   (mac_neg)
    );

    root_side_t rs_in, rs_out;
    logic       sq_valid;
    logic [32:0] sq_len;

    assign rs_in = '{res: mac_res, cmd: mac_cmd, lsq: mac_lsq, mag: mac_mag, neg: mac_neg};

    qalu_sqrt #(.SIDE_W($bits(root_side_t))) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (mac_valid),
        .in_rad    (mac_sqa[63:0]),
        .in_big    (mac_sqa[64]),
        .in_side   (rs_in),
        .out_valid (sq_valid),
        .out_len   (sq_len),
        .out_side  (rs_out)
    );

    div_side_t     ds_in, ds_out;
    logic [DW-1:0] divisor;
    logic          ident;

    always_comb begin
        if (rs_out.cmd == qalu_pkg::OP_INV) begin
            ident   = rs_out.lsq <= {{(DW-16){1'b0}}, eps_reg};
            divisor = rs_out.lsq;
        end else begin
            ident   = sq_len <= {17'd0, eps_reg};
            divisor = {{(DW-33){1'b0}}, sq_len};
        end
        ds_in = '{res: rs_out.res, cmd: rs_out.cmd, ident: ident, len: sq_len};
    end

    logic             dv_valid;
    logic [3:0][31:0] dv_quo;
    logic [3:0]       dv_ovf;
    logic [3:0]       dv_neg;

    qalu_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(div_side_t))) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .in_valid   (sq_valid),
        .in_divisor (divisor),
        .in_mag     (rs_out.mag),
        .in_neg     (rs_out.neg),
        .in_side    (ds_in),
        .out_valid  (dv_valid),
        .out_quo    (dv_quo),
        .out_ovf    (dv_ovf),
        .out_neg    (dv_neg),
        .out_side   (ds_out)
    );

    qalu_pkg::res_t final_res;

    always_comb begin
        final_res = ds_out.res;
        case (ds_out.cmd)
            qalu_pkg::OP_LEN: begin
                if (ds_out.len[32] || ds_out.len[31]) begin
                    final_res.scalar = qalu_pkg::INT_MAX;
                    final_res.sat    = 1'b1;
                end else begin
                    final_res.scalar = ds_out.len[31:0];
                end
            end
            qalu_pkg::OP_NORM, qalu_pkg::OP_INV: begin
                if (ds_out.ident) begin
                    final_res.q[3] = 32'd1 << FRAC_BITS;
                end else begin
                    for (int k = 0; k < 4; k++) begin
                        if (dv_neg[k]) begin
                            if (dv_ovf[k] || dv_quo[k] > qalu_pkg::INT_MIN) begin
                                final_res.q[k] = qalu_pkg::INT_MIN;
                                final_res.sat  = 1'b1;
                            end else begin
                                final_res.q[k] = ~dv_quo[k] + 32'd1;
                            end
                        end else begin
                            if (dv_ovf[k] || dv_quo[k][31]) begin
                                final_res.q[k] = qalu_pkg::INT_MAX;
                                final_res.sat  = 1'b1;
                            end else begin
                                final_res.q[k] = dv_quo[k];
                            end
                        end
                    end
                end
            end
            default: begin
                final_res = ds_out.res;
            end
        endcase
    end

    qalu_pkg::res_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (ce) begin
            m_tvalid <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_reg <= final_res;
        end
    end

    assign m_tdata = {5'd0, out_reg.sat, out_reg.order, out_reg.scalar,
                      out_reg.q[3], out_reg.q[2], out_reg.q[1], out_reg.q[0]};

endmodule

`default_nettype wire

// ===== tb/sv/tb_quaternion_alu_core.sv =====
`timescale 1ns / 100ps

module tb_quaternion_alu_core;

    localparam int FRAC = 16;
    localparam int SETTLE_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [31:0] ONE_Q = 32'h0001_0000;
    localparam logic [31:0] MAX_Q = qalu_pkg::INT_MAX;
    localparam logic [31:0] MIN_Q = qalu_pkg::INT_MIN;

    typedef logic signed [127:0] acc_t;

    logic          aclk;
    logic          aresetn;
    logic          cfg_wr_en;
    logic [15:0]   cfg_wr_data;
    logic          s_tvalid;
    logic          s_tready;
    logic [263:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [167:0]  m_tdata;

    quaternion_alu_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    qalu_pkg::res_t expected_results[$];
    logic [15:0] eps_copy;
    int          mismatches;
    int          idle_cycles;
    int          burst_left;
    int          stall_pct;
    int          stall_left;
    int          op_seen[16];
    int          results_seen;
    int          sat_seen;

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic logic [31:0] clip32(input acc_t v, inout logic sat);
        if (v > acc_t'(32'sh7FFF_FFFF)) begin
            sat = 1'b1;
            return qalu_pkg::INT_MAX;
        end
        if (v < -acc_t'(64'sh8000_0000)) begin
            sat = 1'b1;
            return qalu_pkg::INT_MIN;
        end
        return v[31:0];
    endfunction

    function automatic acc_t round_frac(input acc_t v);
        return (v + (acc_t'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic acc_t floor_sqrt(input acc_t v);
        logic [127:0] rem;
        logic [127:0] root;
        logic [127:0] bitv;
        rem  = v;
        root = '0;
        bitv = 128'd1 << 66;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return acc_t'(root);
    endfunction

    // Works out the single result of one input transaction.
    function automatic qalu_pkg::res_t predict_quaternion(input logic [263:0] d,
                                                          input logic [15:0] eps);
        qalu_pkg::res_t r;
        acc_t a[4];
        acc_t b[4];
        acc_t s;
        acc_t sq_a;
        acc_t sq_b;
        acc_t len;
        logic sat;
        r   = '0;
        sat = 1'b0;
        for (int i = 0; i < 4; i++) begin
            a[i] = acc_t'($signed(d[4 + 32*i +: 32]));
            b[i] = acc_t'($signed(d[132 + 32*i +: 32]));
        end
        sq_a = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
        sq_b = b[0]*b[0] + b[1]*b[1] + b[2]*b[2] + b[3]*b[3];
        case (d[3:0])
            qalu_pkg::OP_MUL: begin
                r.q[0] = clip32(round_frac(a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1]), sat);
                r.q[1] = clip32(round_frac(a[3]*b[1] - a[0]*b[2] + a[1]*b[3] + a[2]*b[0]), sat);
                r.q[2] = clip32(round_frac(a[3]*b[2] + a[0]*b[1] - a[1]*b[0] + a[2]*b[3]), sat);
                r.q[3] = clip32(round_frac(a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2]), sat);
            end
            qalu_pkg::OP_ADD: for (int i = 0; i < 4; i++) r.q[i] = clip32(a[i] + b[i], sat);
            qalu_pkg::OP_SUB: for (int i = 0; i < 4; i++) r.q[i] = clip32(a[i] - b[i], sat);
            qalu_pkg::OP_NEG: for (int i = 0; i < 4; i++) r.q[i] = clip32(-a[i], sat);
            qalu_pkg::OP_CONJ: begin
                for (int i = 0; i < 3; i++) r.q[i] = clip32(-a[i], sat);
                r.q[3] = a[3][31:0];
            end
            qalu_pkg::OP_DOT: begin
                r.scalar = clip32(round_frac(a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3]),
                                  sat);
            end
            qalu_pkg::OP_LENSQ: r.scalar = clip32(round_frac(sq_a), sat);
            qalu_pkg::OP_LEN: r.scalar = clip32(floor_sqrt(sq_a), sat);
            qalu_pkg::OP_NORM: begin
                len = floor_sqrt(sq_a);
                if (len <= acc_t'(eps)) begin
                    r.q[3] = ONE_Q;
                end else begin
                    for (int i = 0; i < 4; i++) r.q[i] = clip32((a[i] <<< FRAC) / len, sat);
                end
            end
            qalu_pkg::OP_INV: begin
                s = round_frac(sq_a);
                if (s <= acc_t'(eps)) begin
                    r.q[3] = ONE_Q;
                end else begin
                    for (int i = 0; i < 3; i++) r.q[i] = clip32((-a[i] <<< FRAC) / s, sat);
                    r.q[3] = clip32((a[3] <<< FRAC) / s, sat);
                end
            end
            qalu_pkg::OP_CMP: begin
                if (sq_a > sq_b) r.order = qalu_pkg::ORD_GT;
                else if (sq_a < sq_b) r.order = qalu_pkg::ORD_LT;
                else r.order = qalu_pkg::ORD_EQ;
            end
            default: ;
        endcase
        r.sat = sat;
        return r;
    endfunction

    // Predicts on every accepted input and checks every accepted result.
    always @(posedge aclk) begin
        qalu_pkg::res_t want;
        qalu_pkg::res_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_quaternion(s_tdata, eps_copy));
                op_seen[s_tdata[3:0]]++;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                for (int i = 0; i < 4; i++) got.q[i] = m_tdata[32*i +: 32];
                got.scalar = m_tdata[159:128];
                got.order  = m_tdata[161:160];
                got.sat    = m_tdata[162];
                if (got.sat) sat_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result transaction %h", m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: q %h/%h %h/%h %h/%h %h/%h scalar %h/%h ",
                                      "order %b/%b sat %b/%b (expected/actual)"},
                                     want.q[0], got.q[0], want.q[1], got.q[1],
                                     want.q[2], got.q[2], want.q[3], got.q[3],
                                     want.scalar, got.scalar, want.order, got.order,
                                     want.sat, got.sat);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Receiver back-pressure: random stalls of random length, density set per test.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left <= $urandom_range(12);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [263:0] pack_item(input logic [3:0] cmd,
                                               input logic [31:0] ax, ay, az, aw,
                                               input logic [31:0] bx, by, bz, bw);
        return {4'b0, bw, bz, by, bx, aw, az, ay, ax, cmd};
    endfunction

    function automatic logic [31:0] rand_component();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(600)) - 300);
            2: return 32'($signed($urandom_range(1 << 18)) - (1 << 17));
            3: begin
                case ($urandom_range(5))
                    0: return MAX_Q;
                    1: return MIN_Q;
                    2: return 32'd0;
                    3: return ONE_Q;
                    4: return -ONE_Q;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic logic [3:0] rand_command();
        if ($urandom_range(19) == 0) return 4'($urandom_range(15, 11));
        return 4'($urandom_range(10));
    endfunction

    task automatic send_quaternion(input logic [263:0] d);
        if (burst_left <= 0) begin
            int gap;
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    task automatic send_random(input int n);
        for (int k = 0; k < n; k++)
            send_quaternion(pack_item(rand_command(),
                                      rand_component(), rand_component(),
                                      rand_component(), rand_component(),
                                      rand_component(), rand_component(),
                                      rand_component(), rand_component()));
    endtask

    // Holds the sender off until the pipeline has delivered everything.
    // The first edge lets the checker record the last accepted transaction.
    task automatic drain_pipeline();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_epsilon(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        eps_copy    = v;
    endtask

    task automatic test_directed();
        stall_pct = 0;
        send_quaternion(pack_item(qalu_pkg::OP_MUL, MIN_Q, MIN_Q, MIN_Q, MIN_Q,
                                  MIN_Q, MIN_Q, MIN_Q, MIN_Q));
        send_quaternion(pack_item(qalu_pkg::OP_MUL, MAX_Q, MAX_Q, MAX_Q, MAX_Q,
                                  MAX_Q, MIN_Q, MAX_Q, MIN_Q));
        send_quaternion(pack_item(qalu_pkg::OP_MUL, 0, 0, 0, ONE_Q,
                                  32'd3, 32'd5, 32'd7, ONE_Q));
        send_quaternion(pack_item(qalu_pkg::OP_ADD, MAX_Q, MIN_Q, 1, -1, MAX_Q, MIN_Q, -1, 1));
        send_quaternion(pack_item(qalu_pkg::OP_SUB, MIN_Q, MAX_Q, 0, 0, MAX_Q, MIN_Q, 0, 1));
        send_quaternion(pack_item(qalu_pkg::OP_NEG, MIN_Q, MAX_Q, 0, 1, 0, 0, 0, 0));
        send_quaternion(pack_item(qalu_pkg::OP_CONJ, MIN_Q, 1, -1, MIN_Q, 0, 0, 0, 0));
        send_quaternion(pack_item(qalu_pkg::OP_DOT, MAX_Q, MAX_Q, MAX_Q, MAX_Q,
                                  MAX_Q, MAX_Q, MAX_Q, MAX_Q));
        send_quaternion(pack_item(qalu_pkg::OP_DOT, 1, 0, 0, 32'h8000, 32'h8000, 0, 0, 1));
        send_quaternion(pack_item(qalu_pkg::OP_LENSQ, MIN_Q, MIN_Q, MIN_Q, MIN_Q,
                                  0, 0, 0, 0));
        send_quaternion(pack_item(qalu_pkg::OP_LEN, MIN_Q, MIN_Q, MIN_Q, MIN_Q, 0, 0, 0, 0));
        send_quaternion(pack_item(qalu_pkg::OP_LEN, MAX_Q, MAX_Q, MAX_Q, MAX_Q, 0, 0, 0, 0));
        send_quaternion(pack_item(qalu_pkg::OP_NORM, 0, 0, 0, 0, 0, 0, 0, 0));
        send_quaternion(pack_item(qalu_pkg::OP_NORM, MIN_Q, MIN_Q, MIN_Q, MIN_Q,
                                  0, 0, 0, 0));
        send_quaternion(pack_item(qalu_pkg::OP_NORM, 1, 0, 0, 1, 0, 0, 0, 0));
        send_quaternion(pack_item(qalu_pkg::OP_INV, 0, 0, 0, 0, 0, 0, 0, 0));
        send_quaternion(pack_item(qalu_pkg::OP_INV, 0, 0, 0, 32'h100, 0, 0, 0, 0));
        send_quaternion(pack_item(qalu_pkg::OP_INV, MIN_Q, 5, 7, ONE_Q, 0, 0, 0, 0));
        send_quaternion(pack_item(qalu_pkg::OP_CMP, 3, 4, 0, 0, 0, 0, 5, 0));
        send_quaternion(pack_item(qalu_pkg::OP_CMP, MIN_Q, 0, 0, 0, MAX_Q, 0, 0, 0));
        send_quaternion(pack_item(qalu_pkg::OP_CMP, 0, 0, 0, 1, 0, 0, 1, 1));
        send_quaternion(pack_item(4'd11, 1, 1, 1, 1, 1, 1, 1, 1));
        send_quaternion(pack_item(4'd15, MIN_Q, MIN_Q, MIN_Q, MIN_Q,
                                  MIN_Q, MIN_Q, MIN_Q, MIN_Q));
        drain_pipeline();
    endtask

    // Normalize and inverse right at the threshold, for a given epsilon.
    task automatic test_threshold(input logic [15:0] v);
        write_epsilon(v);
        stall_pct = 10;
        for (int k = -1; k <= 1; k++) begin
            send_quaternion(pack_item(qalu_pkg::OP_NORM, 32'(int'(v) + k), 0, 0, 0,
                                      0, 0, 0, 0));
            send_quaternion(pack_item(qalu_pkg::OP_INV, 0, 0, 32'(int'(v) + k), 0,
                                      0, 0, 0, 0));
            send_quaternion(pack_item(qalu_pkg::OP_INV, 0, 32'(256 * (int'(v) + k)), 0, 0,
                                      0, 0, 0, 0));
        end
        for (int k = 0; k < 30; k++)
            send_quaternion(pack_item($urandom_range(1) ? qalu_pkg::OP_NORM : qalu_pkg::OP_INV,
                                      32'($signed($urandom_range(2 * v + 4)) - v - 2),
                                      32'($signed($urandom_range(600)) - 300), 0,
                                      32'($urandom_range(v + 2)), 0, 0, 0, 0));
        drain_pipeline();
    endtask

    task automatic test_random(input int n, input int pct);
        stall_pct = pct;
        send_random(n);
    endtask

    task automatic test_pause();
        drain_pipeline();
        stall_pct = 25;
        send_random(50);
        drain_pipeline();
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        eps_copy    = 16'd1;
        mismatches  = 0;
        idle_cycles = 0;
        burst_left  = 0;
        stall_pct   = 0;
        stall_left  = 0;
        results_seen = 0;
        sat_seen    = 0;
        foreach (op_seen[i]) op_seen[i] = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_threshold(16'd0);
        test_threshold(16'd65535);
        test_threshold(16'($urandom_range(2, 65534)));
        write_epsilon(16'd1);
        test_random(400, 0);
        test_random(400, 40);
        test_pause();
        write_epsilon(16'($urandom_range(65535)));
        test_random(400, 10);
        drain_pipeline();

        $display("Covered %0d results (%0d saturated), with epsilon at zero, one, full scale",
                 results_seen, sat_seen);
        $display("and two random values; mul %0d add %0d sub %0d neg %0d conj %0d dot %0d",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5]);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== quaternion_alu_core.f =====
rtl/qalu_pkg.sv
rtl/qalu_mac.sv
rtl/qalu_sqrt.sv
rtl/qalu_div.sv
rtl/quaternion_alu_core.sv
tb/sv/tb_quaternion_alu_core.sv
